// ===== rtl/esd_pkg.sv =====
package esd_pkg;

   // decoder modes
   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_HEX_HI = 2'd2,
      MODE_HEX_LO = 2'd3
   } mode_type;

   // what one character does
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_PUT    = 2'd1,
      ACT_FINISH = 2'd2,
      ACT_FAIL   = 2'd3
   } action_type;

   localparam logic [1:0] STATUS_ONGOING = 2'd0;
   localparam logic [1:0] STATUS_OK      = 2'd1;
   localparam logic [1:0] STATUS_ERROR   = 2'd2;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   localparam logic [7:0] CHAR_END    = 8'hFF;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LA     = 8'h61;
   localparam logic [7:0] CHAR_LB     = 8'h62;
   localparam logic [7:0] CHAR_LF     = 8'h66;
   localparam logic [7:0] CHAR_LN     = 8'h6E;
   localparam logic [7:0] CHAR_LR     = 8'h72;
   localparam logic [7:0] CHAR_LT     = 8'h74;
   localparam logic [7:0] CHAR_LV     = 8'h76;
   localparam logic [7:0] CHAR_LX     = 8'h78;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF     = 8'h46;

   localparam logic [7:0] BYTE_BEL = 8'd7;
   localparam logic [7:0] BYTE_BS  = 8'd8;
   localparam logic [7:0] BYTE_HT  = 8'd9;
   localparam logic [7:0] BYTE_LF  = 8'd10;
   localparam logic [7:0] BYTE_VT  = 8'd11;
   localparam logic [7:0] BYTE_FF  = 8'd12;
   localparam logic [7:0] BYTE_CR  = 8'd13;
   localparam logic [7:0] BYTE_NUL = 8'd0;
   localparam logic [7:0] BYTE_ERR = 8'hFF;

   localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd10;

   typedef struct packed {
      mode_type    mode;
      logic [3:0]  high_nibble;
      logic [15:0] byte_position;
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  out_byte;
      logic        last;
      logic [1:0]  status;
      logic [15:0] final_count;
   } result_type;

   // {ok, value}; ok low for anything outside 0-9a-fA-F
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
         return {1'b1, d[3:0]};
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         d = c - CHAR_LA + HEX_ALPHA_OFFSET;
         return {1'b1, d[3:0]};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA + HEX_ALPHA_OFFSET;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

// ===== rtl/esd_step.sv =====
module esd_step (
   input  esd_pkg::state_type  cur,
   input  logic [15:0]         max_length,
   input  logic [7:0]          in_char,
   input  logic                at_end,
   output esd_pkg::state_type  nxt,
   output esd_pkg::result_type res
);
   import esd_pkg::*;

   logic        end_w;
   logic [4:0]  hex_w;
   action_type  act;
   logic [7:0]  put_byte;
   mode_type    mode_nx;
   logic [3:0]  nib_nx;
   logic [15:0] pos_inc;
   logic [15:0] limit;

   assign end_w   = at_end || (in_char == CHAR_END);
   assign hex_w   = hex_value(in_char);
   assign pos_inc = cur.byte_position + 16'd1;
   assign limit   = (max_length == 16'd0) ? 16'd1 : max_length;

   // mode transitions and action per character
   always_comb begin
      act      = ACT_NONE;
      put_byte = in_char;
      mode_nx  = cur.mode;
      nib_nx   = cur.high_nibble;
      unique case (cur.mode)
         MODE_NORMAL: begin
            if (end_w) act = ACT_FINISH;
            else if (in_char == CHAR_NL) act = ACT_NONE;
            else if (in_char == CHAR_BSLASH) mode_nx = MODE_ESC;
            else act = ACT_PUT;
         end
         MODE_ESC: begin
            if (end_w) begin
               act = ACT_FINISH;
            end else begin
               act = ACT_PUT;
               unique case (in_char)
                  CHAR_NL: act = ACT_NONE;   // line continuation
                  CHAR_LX: begin
                     act     = ACT_NONE;
                     mode_nx = MODE_HEX_HI;
                  end
                  CHAR_LA:     put_byte = BYTE_BEL;
                  CHAR_LB:     put_byte = BYTE_BS;
                  CHAR_LF:     put_byte = BYTE_FF;
                  CHAR_LN:     put_byte = BYTE_LF;
                  CHAR_LR:     put_byte = BYTE_CR;
                  CHAR_LT:     put_byte = BYTE_HT;
                  CHAR_LV:     put_byte = BYTE_VT;
                  CHAR_BSLASH: put_byte = CHAR_BSLASH;
                  CHAR_QUOTE:  put_byte = CHAR_QUOTE;
                  CHAR_DQUOTE: put_byte = CHAR_DQUOTE;
                  CHAR_ZERO:   put_byte = BYTE_NUL;
                  default:     act = ACT_FAIL;
               endcase
            end
         end
         MODE_HEX_HI: begin
            if (end_w || !hex_w[4]) begin
               act = ACT_FAIL;
            end else begin
               nib_nx  = hex_w[3:0];
               mode_nx = MODE_HEX_LO;
            end
         end
         MODE_HEX_LO: begin
            if (end_w || !hex_w[4]) begin
               act = ACT_FAIL;
            end else begin
               act      = ACT_PUT;
               put_byte = {cur.high_nibble, hex_w[3:0]};
               nib_nx   = 4'd0;
            end
         end
         default: act = ACT_FAIL;
      endcase
   end

   // results and position bookkeeping
   always_comb begin
      nxt.mode          = mode_nx;
      nxt.high_nibble   = nib_nx;
      nxt.byte_position = cur.byte_position;
      res.valid         = 1'b0;
      res.out_byte      = put_byte;
      res.last          = 1'b0;
      res.status        = STATUS_ONGOING;
      res.final_count   = 16'd0;
      unique case (act)
         ACT_NONE: ;
         ACT_PUT: begin
            res.valid = 1'b1;
            if (pos_inc >= limit) begin
               nxt.mode          = MODE_NORMAL;
               nxt.high_nibble   = 4'd0;
               nxt.byte_position = 16'd0;
               res.last          = 1'b1;
               if (put_byte != BYTE_NUL) begin
                  res.status = STATUS_ERROR;
               end else begin
                  res.status      = STATUS_OK;
                  res.final_count = pos_inc;
               end
            end else begin
               nxt.mode          = MODE_NORMAL;
               nxt.byte_position = pos_inc;
            end
         end
         ACT_FINISH: begin
            nxt.mode          = MODE_NORMAL;
            nxt.high_nibble   = 4'd0;
            nxt.byte_position = 16'd0;
            res.valid         = 1'b1;
            res.out_byte      = BYTE_NUL;
            res.last          = 1'b1;
            res.status        = STATUS_OK;
            res.final_count   = cur.byte_position;
         end
         ACT_FAIL: begin
            nxt.mode          = MODE_NORMAL;
            nxt.high_nibble   = 4'd0;
            nxt.byte_position = 16'd0;
            res.valid         = 1'b1;
            res.out_byte      = BYTE_ERR;
            res.last          = 1'b1;
            res.status        = STATUS_ERROR;
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/escape_sequence_decoder.sv =====
// A result is loaded into the output register when its item is accepted.
// Throughput: one item per cycle unless a stalled result blocks the input; the decode state
// (mode, high nibble, position) is updated by a single combinational pass and registered
// at each accepted item. Items that are consumed silently (newline, backslash, 'x', high
// hex digit) give no result. Reset (synchronous, active high) returns to normal mode,
// position zero, an empty output register and max_length 256.
module escape_sequence_decoder (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_char,
   input  logic        req_at_end,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_final_count,
   // max_length register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import esd_pkg::*;

   state_type   state_ff, state_in;
   result_type  step_res;
   logic [15:0] max_len_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        accept;

   // The input side only waits when the output register holds an item that
   // the far side is stalling; otherwise a new item goes in every cycle.
   assign req_stall = out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   esd_step u_step (
      .cur        (state_ff),
      .max_length (max_len_ff),
      .in_char    (req_in_char),
      .at_end     (req_at_end),
      .nxt        (state_in),
      .res        (step_res)
   );

   // Output register: loaded on accept, emptied when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (accept) begin
         out_valid_in = step_res.valid;
         out_in       = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= MODE_NORMAL;
         state_ff.high_nibble   <= 4'd0;
         state_ff.byte_position <= 16'd0;
         max_len_ff             <= MAX_LENGTH_RESET;
         out_valid_ff           <= 1'b0;
      end else begin
         if (accept) state_ff <= state_in;
         if (csr_wr_en) max_len_ff <= csr_wr_data;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_ff.out_byte;
   assign rsp_byte_valid  = out_ff.valid;   // every delivered item carries a byte
   assign rsp_last        = out_ff.last;
   assign rsp_status      = out_ff.status;
   assign rsp_final_count = out_ff.final_count;

   // A string end leaves the decoder in a fresh state.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && step_res.valid && step_res.last |=>
         state_ff.mode == MODE_NORMAL && state_ff.byte_position == 16'd0)
      else $error("decoder did not restart after end of string");

   // The high nibble is only held while inside a hex escape.
   a_nibble_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_NORMAL || state_ff.mode == MODE_ESC |->
         state_ff.high_nibble == 4'd0)
      else $error("stale high nibble outside hex escape");

   // Ongoing items carry no status and no count.
   a_ongoing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STATUS_ONGOING && rsp_final_count == 16'd0)
      else $error("non-final item with status or count");

   // Normal finish is always a zero byte that ends the string.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_last && rsp_out_byte == BYTE_NUL)
      else $error("normal finish without zero terminator");

endmodule

// ===== tb/sv/tb_escape_sequence_decoder.sv =====
`timescale 1ns / 1ps

module tb_escape_sequence_decoder;
   import esd_pkg::*;

   // cycle budget: ~1400 items, each with a random sender gap and receiver stall on top
   // of its own handling, plus one long receiver hold; taken roughly ten times over
   localparam int unsigned CYCLE_LIMIT = 500000;
   // receiver hold-off for the backpressure phase
   localparam int HOLD_CYCLES = 300;
   // settle time after the last expected result
   localparam int DRAIN_CYCLES = 8;

   // ------------------------------------------------------------------
   // Decode predictor plus the queue of result items still owed by the block.
   // Tracks its own copy of the string state and the max_length register.
   // ------------------------------------------------------------------
   class decoded_byte_tracker;
      logic [15:0] max_len;
      mode_type    mode;
      logic [3:0]  hi_digit;
      logic [15:0] position;
      result_type  pending_bytes[$];
      int          mismatches;

      function new();
         max_len    = MAX_LENGTH_RESET;
         mismatches = 0;
         restart_string();
      endfunction

      function void restart_string();
         mode     = MODE_NORMAL;
         hi_digit = 4'd0;
         position = 16'd0;
      endfunction

      function void write_limit(logic [15:0] value);
         max_len = value;
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction

      function void queue_result(logic [7:0] b, logic last, logic [1:0] st,
                                 logic [15:0] cnt);
         result_type r;
         r.valid       = 1'b1;
         r.out_byte    = b;
         r.last        = last;
         r.status      = st;
         r.final_count = cnt;
         pending_bytes.push_back(r);
      endfunction

      // -1 for anything outside 0-9, a-f, A-F
      function int digit_of(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
         if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
         if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
         return -1;
      endfunction

      function void finish_string();
         queue_result(BYTE_NUL, 1'b1, STATUS_OK, position);
         restart_string();
      endfunction

      function void abort_string();
         queue_result(BYTE_ERR, 1'b1, STATUS_ERROR, 16'd0);
         restart_string();
      endfunction

      // one written byte; a string that reaches max_length ends here
      function void push_byte(logic [7:0] b);
         logic [15:0] lim;
         logic [15:0] count;
         lim      = (max_len == 16'd0) ? 16'd1 : max_len;
         position = position + 16'd1;
         mode     = MODE_NORMAL;
         if (position >= lim) begin
            count = position;
            restart_string();
            if (b != BYTE_NUL) queue_result(b, 1'b1, STATUS_ERROR, 16'd0);
            else queue_result(BYTE_NUL, 1'b1, STATUS_OK, count);
         end else begin
            queue_result(b, 1'b0, STATUS_ONGOING, 16'd0);
         end
      endfunction

      function void note_char(logic [7:0] c, logic at_end);
         logic stop;
         int   d;
         stop = at_end || (c == CHAR_END);
         case (mode)
            MODE_NORMAL: begin
               if (stop) finish_string();
               else if (c == CHAR_BSLASH) mode = MODE_ESC;
               else if (c != CHAR_NL) push_byte(c);
            end
            MODE_ESC: begin
               if (stop) finish_string();
               else if (c == CHAR_LX) mode = MODE_HEX_HI;
               else if (c != CHAR_NL) begin
                  case (c)
                     CHAR_LA: push_byte(BYTE_BEL);
                     CHAR_LB: push_byte(BYTE_BS);
                     CHAR_LF: push_byte(BYTE_FF);
                     CHAR_LN: push_byte(BYTE_LF);
                     CHAR_LR: push_byte(BYTE_CR);
                     CHAR_LT: push_byte(BYTE_HT);
                     CHAR_LV: push_byte(BYTE_VT);
                     CHAR_BSLASH, CHAR_QUOTE, CHAR_DQUOTE: push_byte(c);
                     CHAR_ZERO: push_byte(BYTE_NUL);
                     default: abort_string();
                  endcase
               end
            end
            MODE_HEX_HI: begin
               d = stop ? -1 : digit_of(c);
               if (d < 0) abort_string();
               else begin
                  hi_digit = d[3:0];
                  mode     = MODE_HEX_LO;
               end
            end
            default: begin
               d = stop ? -1 : digit_of(c);
               if (d < 0) abort_string();
               else begin
                  d        = int'(hi_digit) * 16 + d;
                  hi_digit = 4'd0;
                  push_byte(d[7:0]);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_byte(logic [7:0] b, logic bv, logic last, logic [1:0] st,
                               logic [15:0] cnt);
         result_type want;
         if (pending_bytes.size() == 0) begin
            $error("unexpected result item: out_byte %0d status %0d", b, st);
            mismatches++;
         end else begin
            want = pending_bytes.pop_front();
            compare_field("out_byte", want.out_byte, b);
            compare_field("byte_valid", want.valid, bv);
            compare_field("last", want.last, last);
            compare_field("status", want.status, st);
            compare_field("final_count", want.final_count, cnt);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_char = 8'd0;
   logic        req_at_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_final_count;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   escape_sequence_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_at_end      (req_at_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_final_count (rsp_final_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   decoded_byte_tracker tracker;

   bit          tx_idle = 1'b0;      // sender inserts random gaps
   bit          rx_idle = 1'b0;      // receiver inserts random stalls
   bit          rsp_hold_req = 1'b0; // ask the receiver for one long hold-off
   int          chars_sent = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog: a hung handshake ends the run here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("escape_sequence_decoder verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, so it sees the
   // values that the block itself saw. A result accepted at this edge always
   // belongs to an earlier item, so it is checked before the new item is noted.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_byte(rsp_out_byte, rsp_byte_valid, rsp_last, rsp_status,
                               rsp_final_count);
         if (req_valid && !req_stall) tracker.note_char(req_in_char, req_at_end);
         if (csr_wr_en) tracker.write_limit(csr_wr_data);
      end
   end

   // ------------------------------------------------------------------
   // Result sink: after each accepted result, stall at random (when enabled).
   // A hold request stalls for HOLD_CYCLES on top, counted here.
   // ------------------------------------------------------------------
   initial begin : result_sink
      int wait_left;
      int hold_left;
      wait_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         if (rsp_valid && !rsp_stall) wait_left = rx_idle ? $urandom_range(0, 15) : 0;
         else if (wait_left > 0) wait_left--;
         rsp_stall <= (hold_left > 0) || (wait_left > 0);
      end
   end

   // ------------------------------------------------------------------
   // Sender. Called at a rising edge, returns at the edge that accepted the item.
   // Valid is only lowered when a gap follows, so it never toggles within a step.
   // ------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic at_end);
      int gap;
      gap = tx_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      req_at_end  <= at_end;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k], 1'b0);
   endtask

   // idle the input, then wait out every owed result plus the block latency
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [15:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] escape_letter(int k);
      case (k)
         0:  return CHAR_LA;
         1:  return CHAR_LB;
         2:  return CHAR_LF;
         3:  return CHAR_LN;
         4:  return CHAR_LR;
         5:  return CHAR_LT;
         6:  return CHAR_LV;
         7:  return CHAR_BSLASH;
         8:  return CHAR_QUOTE;
         9:  return CHAR_DQUOTE;
         default: return CHAR_ZERO;
      endcase
   endfunction

   // mostly a valid hex digit in either case, now and then any byte at all
   function automatic logic [7:0] hex_char();
      int v;
      if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
      v = $urandom_range(0, 15);
      if (v < 10) return CHAR_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(v) - HEX_ALPHA_OFFSET;
   endfunction

   // one random token: mostly well-formed text and escapes, some noise
   task automatic send_token();
      int         pick;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // plain byte, including the zero byte now and then
         c = 8'($urandom_range(0, 254));
         if (c == CHAR_NL || c == CHAR_BSLASH) c = CHAR_UA;
         if ($urandom_range(0, 19) == 0) c = BYTE_NUL;
         send_char(c, 1'b0);
      end else if (pick < 65) begin
         // simple escape, sometimes split by a line continuation
         send_char(CHAR_BSLASH, 1'b0);
         if ($urandom_range(0, 9) == 0) send_char(CHAR_NL, 1'b0);
         send_char(escape_letter($urandom_range(0, 10)), 1'b0);
      end else if (pick < 80) begin
         send_char(CHAR_BSLASH, 1'b0);
         send_char(CHAR_LX, 1'b0);
         send_char(hex_char(), 1'b0);
         send_char(hex_char(), 1'b0);
      end else if (pick < 86) begin
         // escape with an arbitrary letter, usually unknown
         send_char(CHAR_BSLASH, 1'b0);
         send_char(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 90) begin
         send_char(CHAR_NL, 1'b0);
      end else if (pick < 96) begin
         // end of input, by flag or by the 0xFF character
         if ($urandom_range(0, 1)) send_char(8'($urandom_range(0, 255)), 1'b1);
         else send_char(CHAR_END, 1'b0);
      end else begin
         send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      stop_at = chars_sent + count;
      while (chars_sent < stop_at) send_token();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, line drops, escapes, hex, each way to end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      send_char(8'h41, 1'b0);
      send_char(8'h00, 1'b0);         // zero byte mid-string is just data
      send_char(8'hFE, 1'b0);
      send_char(CHAR_NL, 1'b0);       // plain newline dropped
      send_text("\\\na");             // newline between backslash and letter
      send_text("\\\"\\xfF\\x09");    // quote escape, hex in both cases
      send_char(CHAR_END, 1'b0);      // 0xFF ends the string
      send_text("\\q");               // unknown escape
      send_text("\\xg");              // bad high digit
      send_text("\\xa");
      send_char(8'h00, 1'b1);         // end inside \x -> error
      send_char(CHAR_BSLASH, 1'b0);
      send_char(8'h00, 1'b1);         // end right after backslash -> normal finish

      run_random(280);

      // backpressure: receiver holds off while the sender keeps offering,
      // so the block fills up and stalls its input
      tx_idle      = 1'b0;
      rsp_hold_req = 1'b1;
      send_text("the quick brown fox jumps over the lazy dog");
      tx_idle = 1'b1;

      // every written byte ends the string
      write_max_length(16'd1);
      run_random(150);

      // zero limit acts as one; no idling on either side here
      write_max_length(16'd0);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      run_random(120);

      write_max_length(16'hFFFF);
      tx_idle = 1'b1;
      run_random(200);
      // leave a fresh string open, then lower the limit below its position
      send_char(CHAR_END, 1'b0);
      send_text("abcdefgh");

      write_max_length(16'd3);
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      run_random(200);

      for (int p = 0; p < 4; p++) begin
         write_max_length(16'($urandom_range(2, 40)));
         tx_idle = 1'b1;
         rx_idle = $urandom_range(0, 1);
         run_random(100);
      end

      drain();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("escape_sequence_decoder verification clean");
      end else begin
         $display("escape_sequence_decoder verification failed");
      end
      $finish;
   end

endmodule
